>>> hdl/rc5d_pkg.sv
// Shared types and constants for the RC5 IR frame decoder.
`timescale 1ns / 1ps

package rc5d_pkg;

    // Defaults for top-level parameters
    localparam int FRAME_LENGTH_DEF = 13;
    localparam int TICK_BITS_DEF    = 16;

    // Bits kept from a frame: start2, toggle, 5 address, 6 command
    localparam int KEPT_BITS    = 13;
    localparam int ADDR_W       = 5;
    localparam int CMD_W        = 7;
    localparam int CMD_LOW_W    = 6;
    localparam int BITS_TAKEN_W = 4;

    // Configuration port
    localparam int CFG_W       = 16;
    localparam int APB_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 1'b1;

    localparam logic [CFG_W-1:0] START_DELAY_RST     = 16'd444;
    localparam logic [CFG_W-1:0] SAMPLE_INTERVAL_RST = 16'd889;

    // Result queue between decoder and output channel
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DELAY,
        PH_FIRST,
        PH_SECOND
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] start_delay;
        logic [CFG_W-1:0] sample_interval;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [CMD_W-1:0]  command;
    } frame_t;

    typedef struct packed {
        logic   valid;
        frame_t frame;
    } frame_push_t;

endpackage

>>> hdl/rc5d_in_if.sv
// Channel carrying receiver level samples.
`timescale 1ns / 1ps

interface rc5d_in_if;
    logic valid;
    logic ready;
    logic ir_level;

    modport source (output valid, output ir_level, input ready);
    modport sink (input valid, input ir_level, output ready);
endinterface

>>> hdl/rc5d_out_if.sv
// Channel carrying decoded frames.
`timescale 1ns / 1ps

interface rc5d_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] address;
    logic [6:0] command;

    modport source (output valid, output address, output command, input ready);
    modport sink (input valid, input address, input command, output ready);
endinterface

>>> hdl/rc5_ir_frame_decoder.sv
// Top level of the RC5 IR frame decoder: config regs, decoder, output queue.
// Throughput: one level sample per clock; a sample transaction is taken every cycle
//   unless the output queue already holds two undelivered frames.
// Output: the sample that completes a frame's last bit writes it into the queue; it is
//   offered after older frames; depth (two frames) sets how long the sink may stall.
// Reset: rst_n asynchronous active low; decoder idle with line assumed high,
//   queue empty, start_delay 444 and sample_interval 889.
`timescale 1ns / 1ps

module rc5_ir_frame_decoder
    import rc5d_pkg::*;
#(
    parameter int FRAME_LENGTH = FRAME_LENGTH_DEF,
    parameter int TICK_BITS    = TICK_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    rc5d_in_if.sink               samples,
    rc5d_out_if.source            frames,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t        cfg;
    frame_push_t frame_push;
    logic        queue_full;
    logic        tick;

    // Front end keeps pace with the sample stream; it only waits when
    // the queue has no room for a frame that might complete.
    assign samples.ready = !queue_full;
    assign tick          = samples.valid && samples.ready;

    rc5d_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Edge detect, half-bit sampling and bit assembly
    rc5d_front #(
        .FRAME_LENGTH (FRAME_LENGTH),
        .TICK_BITS    (TICK_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .tick     (tick),
        .ir_level (samples.ir_level),
        .push     (frame_push)
    );

    // Finished frames wait here for the sink
    rc5d_out_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (frame_push),
        .full   (queue_full),
        .frames (frames)
    );

    // A frame is only produced by an accepted sample transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_push.valid |-> tick)
    else $error("frame pushed without an accepted sample");

    // Output valid can only rise after a push
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frames.valid) |-> $past(frame_push.valid))
    else $error("output valid rose without a queued frame");

    // A start_delay write lands in the register
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] == REG_START_DELAY)
        |=> cfg.start_delay == $past(pwdata[CFG_W-1:0]))
    else $error("start_delay write lost");

endmodule

>>> hdl/rc5d_apb_regs.sv
// APB register block holding the timing configuration.
`timescale 1ns / 1ps

module rc5d_apb_regs
    import rc5d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_START_DELAY:     cfg_next.start_delay     = pwdata[CFG_W-1:0];
                REG_SAMPLE_INTERVAL: cfg_next.sample_interval = pwdata[CFG_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_START_DELAY:     prdata = APB_DATA_W'(cfg_reg.start_delay);
            REG_SAMPLE_INTERVAL: prdata = APB_DATA_W'(cfg_reg.sample_interval);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_delay     <= START_DELAY_RST;
            cfg_reg.sample_interval <= SAMPLE_INTERVAL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/rc5d_front.sv
// Manchester decoder: edge detect, half-bit timing and frame assembly.
`timescale 1ns / 1ps

module rc5d_front
    import rc5d_pkg::*;
#(
    parameter int FRAME_LENGTH = FRAME_LENGTH_DEF,
    parameter int TICK_BITS    = TICK_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        tick,
    input  logic        ir_level,
    output frame_push_t push
);

    phase_t                  phase_reg,      phase_next;
    logic [TICK_BITS-1:0]    tick_count_reg, tick_count_next;
    logic [BITS_TAKEN_W-1:0] bits_taken_reg, bits_taken_next;
    logic [KEPT_BITS-1:0]    frame_bits_reg, frame_bits_next;
    logic                    first_half_reg, first_half_next;
    logic                    last_level_reg, last_level_next;

    logic                    fire;
    logic [KEPT_BITS-1:0]    shifted;
    logic [BITS_TAKEN_W-1:0] bits_inc;
    logic [TICK_BITS-1:0]    delay_load;
    logic [TICK_BITS-1:0]    interval_load;

    // A count of zero or one both expire on this tick
    assign fire          = (tick_count_reg <= TICK_BITS'(1));
    assign shifted       = {frame_bits_reg[KEPT_BITS-2:0], first_half_reg};
    assign bits_inc      = bits_taken_reg + BITS_TAKEN_W'(1);
    assign delay_load    = TICK_BITS'(cfg.start_delay);
    assign interval_load = TICK_BITS'(cfg.sample_interval);

    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bits_taken_next = bits_taken_reg;
        frame_bits_next = frame_bits_reg;
        first_half_next = first_half_reg;
        last_level_next = last_level_reg;
        push.valid      = 1'b0;
        push.frame.address = shifted[CMD_LOW_W +: ADDR_W];
        push.frame.command = {shifted[KEPT_BITS-1], shifted[CMD_LOW_W-1:0]};

        if (tick)
        begin
            last_level_next = ir_level;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (last_level_reg && !ir_level)
                    begin
                        phase_next      = PH_DELAY;
                        tick_count_next = delay_load;
                        bits_taken_next = '0;
                        frame_bits_next = '0;
                    end
                end
                PH_DELAY:
                begin
                    if (fire)
                    begin
                        tick_count_next = interval_load;
                        phase_next      = PH_FIRST;
                    end
                    else
                    begin
                        tick_count_next = tick_count_reg - TICK_BITS'(1);
                    end
                end
                PH_FIRST:
                begin
                    if (fire)
                    begin
                        first_half_next = ir_level;
                        tick_count_next = interval_load;
                        phase_next      = PH_SECOND;
                    end
                    else
                    begin
                        tick_count_next = tick_count_reg - TICK_BITS'(1);
                    end
                end
                PH_SECOND:
                begin
                    if (fire)
                    begin
                        tick_count_next = interval_load;
                        if (first_half_reg != ir_level)
                        begin
                            frame_bits_next = shifted;
                            bits_taken_next = bits_inc;
                            if (bits_inc >= BITS_TAKEN_W'(FRAME_LENGTH))
                            begin
                                push.valid = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_FIRST;
                            end
                        end
                        else
                        begin
                            // equal halves: not Manchester, drop the frame
                            phase_next = PH_IDLE;
                        end
                    end
                    else
                    begin
                        tick_count_next = tick_count_reg - TICK_BITS'(1);
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            bits_taken_reg <= '0;
            frame_bits_reg <= '0;
            first_half_reg <= 1'b0;
            last_level_reg <= 1'b1;
        end
        else
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bits_taken_reg <= bits_taken_next;
            frame_bits_reg <= frame_bits_next;
            first_half_reg <= first_half_next;
            last_level_reg <= last_level_next;
        end
    end

endmodule

>>> hdl/rc5d_out_queue.sv
// Two-entry frame queue driving the output channel.
`timescale 1ns / 1ps

module rc5d_out_queue
    import rc5d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  frame_push_t       push,
    output logic              full,
    rc5d_out_if.source        frames
);

    frame_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;
    logic                pop;

    assign full           = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign frames.valid   = (count_reg != '0);
    assign frames.address = entry_reg[rd_ptr_reg].address;
    assign frames.command = entry_reg[rd_ptr_reg].command;
    assign pop            = frames.valid && frames.ready;

    always_comb
    begin
        wr_ptr_next = push.valid ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.frame;
        end
    end

endmodule

>>> sim/tb_rc5_ir_frame_decoder.sv
// Self-checking testbench for the RC5 IR frame decoder: level sample stimulus, APB setup, frame check.
`timescale 1ns / 1ps

module tb_rc5_ir_frame_decoder;
    import rc5d_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 2_000_000;
    // Extra idle clocks after every frame has arrived, for margin
    localparam int DRAIN_CYCLES = 8;
    localparam int GAP_MAX      = 15;
    // Random part stops once both of these are reached
    localparam int RAND_SAMPLES = 1100;
    localparam int RAND_FRAMES  = 10;
    localparam int NO_ABORT     = -1;

    // One level sample waiting for the driver, with its pre-transaction gap
    typedef struct {
        logic        level;
        int unsigned gap;
    } sample_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rc5d_in_if  samples_if ();
    rc5d_out_if frames_if ();

    rc5_ir_frame_decoder i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .frames  (frames_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Decoder predictor: own copy of timing registers and decode state
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]        timing_delay;
    logic [CFG_W-1:0]        timing_interval;
    phase_t                  dec_phase;
    logic [TICK_BITS_DEF-1:0] dec_count;
    logic [BITS_TAKEN_W-1:0] dec_taken;
    logic [KEPT_BITS-1:0]    dec_bits;
    logic                    dec_first;
    logic                    dec_last_level;

    frame_t      frames_due[$];
    sample_t     sample_q[$];
    logic        wave_q[$];

    int unsigned src_gap_max;
    int unsigned sink_gap_max;
    int unsigned src_wait;
    int unsigned sink_hold;
    bit          in_taken;
    bit          out_taken;

    int unsigned err_cnt;
    int unsigned cycles;
    int unsigned samples_sent;
    int unsigned samples_queued;
    int unsigned frames_checked;
    int unsigned frames_planned;
    int unsigned reg_writes;

    // Countdown: fires when the count has run down to one (zero behaves as one)
    function automatic bit countdown_done();
        if (dec_count <= 1)
        begin
            return 1'b1;
        end
        dec_count = dec_count - 1'b1;
        return 1'b0;
    endfunction

    // One receiver tick; returns 1 with the decoded frame when the last bit lands
    function automatic bit decode_tick(input logic lvl, output frame_t fr);
        bit got;
        got = 1'b0;
        fr  = '0;
        case (dec_phase)
            PH_IDLE:
            begin
                // only a high-to-low transition opens a frame
                if (dec_last_level && !lvl)
                begin
                    dec_phase = PH_DELAY;
                    dec_count = timing_delay;
                    dec_taken = '0;
                    dec_bits  = '0;
                end
            end
            PH_DELAY:
            begin
                if (countdown_done())
                begin
                    dec_count = timing_interval;
                    dec_phase = PH_FIRST;
                end
            end
            PH_FIRST:
            begin
                if (countdown_done())
                begin
                    dec_first = lvl;
                    dec_count = timing_interval;
                    dec_phase = PH_SECOND;
                end
            end
            default:
            begin
                if (countdown_done())
                begin
                    dec_count = timing_interval;
                    if (dec_first != lvl)
                    begin
                        dec_bits  = {dec_bits[KEPT_BITS-2:0], dec_first};
                        dec_taken = dec_taken + 1'b1;
                        if (int'(dec_taken) >= FRAME_LENGTH_DEF)
                        begin
                            // start2 | toggle | address | command low bits
                            fr.address = dec_bits[CMD_LOW_W +: ADDR_W];
                            fr.command = {dec_bits[KEPT_BITS-1], dec_bits[CMD_LOW_W-1:0]};
                            got        = 1'b1;
                            dec_phase  = PH_IDLE;
                        end
                        else
                        begin
                            dec_phase = PH_FIRST;
                        end
                    end
                    else
                    begin
                        // equal halves: frame dropped without a word
                        dec_phase = PH_IDLE;
                    end
                end
            end
        endcase
        dec_last_level = lvl;
        return got;
    endfunction

    // Tick on which a countdown of v fires, counted from its load
    function automatic int unsigned fire_after(input logic [CFG_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        return 32'(v);
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sample driver: one queued level per transaction, random gap first.
    // Changes on the falling edge only; valid is held until accepted.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            samples_if.valid <= 1'b0;
        end
        else if (samples_if.valid && !in_taken)
        begin
            // still waiting for ready, hold everything
        end
        else if (sample_q.size() != 0 && src_wait < sample_q[0].gap)
        begin
            src_wait++;
            samples_if.valid <= 1'b0;
        end
        else if (sample_q.size() != 0)
        begin
            samples_if.valid    <= 1'b1;
            samples_if.ir_level <= sample_q[0].level;
            void'(sample_q.pop_front());
            src_wait = 0;
        end
        else
        begin
            samples_if.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Frame sink: after each transaction draw a stall of 0..sink_gap_max
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            frames_if.ready <= 1'b0;
        end
        else
        begin
            if (out_taken)
            begin
                sink_hold = $urandom_range(0, sink_gap_max);
            end
            if (sink_hold != 0)
            begin
                sink_hold--;
                frames_if.ready <= 1'b0;
            end
            else
            begin
                frames_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on each sample transaction, checks each frame
    // transaction against the oldest prediction. Sample push comes first,
    // though a frame can never leave on the edge that completes it.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        frame_t fr;
        frame_t want;
        in_taken  = rst_n && samples_if.valid && samples_if.ready;
        out_taken = rst_n && frames_if.valid && frames_if.ready;
        if (in_taken)
        begin
            samples_sent++;
            if (decode_tick(samples_if.ir_level, fr))
            begin
                frames_due.push_back(fr);
            end
        end
        if (out_taken)
        begin
            if (frames_due.size() == 0)
            begin
                $error("unexpected frame: address %0d, command %0d",
                       frames_if.address, frames_if.command);
                err_cnt++;
            end
            else
            begin
                want = frames_due.pop_front();
                frames_checked++;
                if (frames_if.address !== want.address)
                begin
                    $error("address: expected %0d, got %0d", want.address, frames_if.address);
                    err_cnt++;
                end
                if (frames_if.command !== want.command)
                begin
                    $error("command: expected %0d, got %0d", want.command, frames_if.command);
                    err_cnt++;
                end
            end
        end
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles, %0d frames outstanding",
                     cycles, frames_due.size());
            $display("tb_rc5_ir_frame_decoder: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Lay out one frame as levels in wave_q. Sample ticks sit at
    // delay + k*interval from the falling edge; ticks in between carry the
    // coming sample's level, or noise when noisy is set. An abort pair gets
    // equal halves and the frame stops there.
    task automatic build_frame(input logic [CFG_W-1:0] d, input logic [CFG_W-1:0] iv,
                               input logic [KEPT_BITS-1:0] bits, input int unsigned lead,
                               input int abort_pair, input bit noisy);
        int unsigned tick;
        int unsigned t_next;
        int          j;
        logic        b;
        logic        lvl;
        repeat (lead) wave_q.push_back(1'b1);
        wave_q.push_back(1'b0);
        tick = 0;
        for (int k = 1; k <= 2 * KEPT_BITS; k++)
        begin
            j = (k - 1) / 2;
            b = bits[KEPT_BITS-1-j];
            if (k % 2 == 1)
            begin
                lvl = b;
            end
            else
            begin
                lvl = (j == abort_pair) ? b : ~b;
            end
            t_next = fire_after(d) + fire_after(iv) * k;
            while (tick + 1 < t_next)
            begin
                wave_q.push_back(noisy ? 1'($urandom_range(0, 1)) : lvl);
                tick++;
            end
            wave_q.push_back(lvl);
            tick++;
            if (k % 2 == 0 && j == abort_pair)
            begin
                break;
            end
        end
    endtask

    // Move up to n levels (all when n < 0) to the driver, each with a gap
    task automatic send_wave(input int n);
        sample_t s;
        while (wave_q.size() != 0 && n != 0)
        begin
            s.level = wave_q.pop_front();
            s.gap   = $urandom_range(0, src_gap_max);
            sample_q.push_back(s);
            samples_queued++;
            n--;
        end
    endtask

    task automatic send_frame(input logic [KEPT_BITS-1:0] bits, input int abort_pair,
                              input bit noisy);
        build_frame(timing_delay, timing_interval, bits, $urandom_range(1, 4),
                    abort_pair, noisy);
        send_wave(-1);
    endtask

    // Idle high long enough that any half-decoded frame dies on equal halves
    task automatic send_flush();
        repeat (fire_after(timing_delay) + 3 * fire_after(timing_interval) + 2)
            wave_q.push_back(1'b1);
        send_wave(-1);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(5, 40)) wave_q.push_back(1'($urandom_range(0, 1)));
        send_flush();
    endtask

    // Sender holds off until all levels are gone and every frame has arrived
    task automatic wait_idle();
        while (sample_q.size() != 0 || samples_if.valid || frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_read_check(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== APB_DATA_W'(want))
        begin
            $error("%s readback: expected %0d, got %0d",
                   (idx == REG_START_DELAY) ? "start_delay" : "sample_interval",
                   want, prdata);
            err_cnt++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write then read back; the register keeps the low 16 bits
    task automatic apb_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == REG_START_DELAY)
        begin
            timing_delay = data[CFG_W-1:0];
        end
        else
        begin
            timing_interval = data[CFG_W-1:0];
        end
        reg_writes++;
        apb_read_check(idx, data[CFG_W-1:0]);
    endtask

    task automatic set_timing(input logic [APB_DATA_W-1:0] d,
                              input logic [APB_DATA_W-1:0] iv);
        wait_idle();
        apb_write(REG_START_DELAY, d);
        apb_write(REG_SAMPLE_INTERVAL, iv);
    endtask

    // Mostly tiny counts so frames stay short; now and then zero or larger,
    // sometimes with junk above bit 15
    function automatic logic [APB_DATA_W-1:0] pick_count(input int unsigned top);
        int unsigned          r;
        logic [APB_DATA_W-1:0] v;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            v = '0;
        end
        else if (r < 8)
        begin
            v = $urandom_range(1, 4);
        end
        else
        begin
            v = $urandom_range(5, top);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            v[APB_DATA_W-1:CFG_W] = 16'($urandom);
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned rand_start;
        int unsigned roll;

        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        samples_if.valid    = 1'b0;
        samples_if.ir_level = 1'b1;
        frames_if.ready     = 1'b0;

        timing_delay    = START_DELAY_RST;
        timing_interval = SAMPLE_INTERVAL_RST;
        dec_phase       = PH_IDLE;
        dec_count       = '0;
        dec_taken       = '0;
        dec_bits        = '0;
        dec_first       = 1'b0;
        dec_last_level  = 1'b1;

        src_gap_max    = 0;
        sink_gap_max   = 0;
        src_wait       = 0;
        sink_hold      = 0;
        in_taken       = 1'b0;
        out_taken      = 1'b0;
        err_cnt        = 0;
        cycles         = 0;
        samples_sent   = 0;
        samples_queued = 0;
        frames_checked = 0;
        frames_planned = 0;
        reg_writes     = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Reset values
        apb_read_check(REG_START_DELAY, START_DELAY_RST);
        apb_read_check(REG_SAMPLE_INTERVAL, SAMPLE_INTERVAL_RST);

        // Fastest timing, both sides stalling; field extremes and patterns
        set_timing(32'd1, 32'd1);
        src_gap_max  = GAP_MAX;
        sink_gap_max = GAP_MAX;
        send_frame(13'h0000, NO_ABORT, 1'b0);
        send_frame(13'h1555, NO_ABORT, 1'b0);
        send_frame(13'h0AAA, NO_ABORT, 1'b1);
        send_frame(13'h1FFF, NO_ABORT, 1'b0);

        // Broken pairs: high-high on the first, low-low on the last; then recovery
        send_frame(13'h1FFF, 0, 1'b0);
        send_frame(13'h0000, KEPT_BITS - 1, 1'b0);
        send_frame(13'h1234, NO_ABORT, 1'b0);

        // Line already low after a frame: a low start tick must not open one
        send_frame(13'h0001, NO_ABORT, 1'b0);
        build_frame(timing_delay, timing_interval, 13'h1ABC, 0, NO_ABORT, 1'b0);
        send_wave(-1);
        send_flush();
        send_frame(13'h0F0F, NO_ABORT, 1'b0);

        // Counts of zero after truncation behave as one
        set_timing(32'h0001_0000, 32'h0000_0000);
        send_frame(13'h1C3A, NO_ABORT, 1'b0);

        // Upper bits of the write data are dropped
        set_timing(32'h0001_0002, 32'hABCD_0003);
        send_frame(13'h0E55, NO_ABORT, 1'b1);

        // Interval changed during the start countdown: new value at next reload
        set_timing(32'd3, 32'd2);
        build_frame(16'd3, 16'd4, 13'h16D9, 2, NO_ABORT, 1'b0);
        send_wave(4);
        wait_idle();
        apb_write(REG_SAMPLE_INTERVAL, 32'd4);
        send_wave(-1);

        // Widest counts: register write and readback only
        set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Random part: phases with fresh timing and idling, mostly good frames
        rand_start = samples_queued;
        while (frames_planned < RAND_FRAMES || samples_queued - rand_start < RAND_SAMPLES)
        begin
            set_timing(pick_count(24), pick_count(10));
            src_gap_max  = ($urandom_range(0, 2) != 0) ? GAP_MAX : 0;
            sink_gap_max = ($urandom_range(0, 2) != 0) ? GAP_MAX : 0;
            repeat ($urandom_range(3, 8))
            begin
                roll = $urandom_range(0, 19);
                if (roll < 15)
                begin
                    send_frame(KEPT_BITS'($urandom), NO_ABORT, roll < 4);
                    frames_planned++;
                end
                else if (roll < 17)
                begin
                    send_frame(KEPT_BITS'($urandom), $urandom_range(0, KEPT_BITS - 1),
                               roll == 16);
                end
                else
                begin
                    send_noise();
                end
            end
        end

        wait_idle();

        $display("%0d level samples, %0d frames checked, %0d register writes",
                 samples_sent, frames_checked, reg_writes);
        $display("zero and small counts on the line, 16-bit extremes by readback, broken pairs and line noise");
        if (err_cnt == 0)
        begin
            $display("tb_rc5_ir_frame_decoder: clean");
        end
        else
        begin
            $display("tb_rc5_ir_frame_decoder: errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/rc5d_pkg.sv
hdl/rc5d_in_if.sv
hdl/rc5d_out_if.sv
hdl/rc5d_apb_regs.sv
hdl/rc5d_front.sv
hdl/rc5d_out_queue.sv
hdl/rc5_ir_frame_decoder.sv
sim/tb_rc5_ir_frame_decoder.sv
